// ===== rtl/lru_insert_at_kth_oldest_policy_unit_macros.svh =====
// Assertion macros for the replacement policy unit.
`ifndef LRU_INSERT_AT_KTH_OLDEST_POLICY_UNIT_MACROS_SVH
`define LRU_INSERT_AT_KTH_OLDEST_POLICY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LRUK_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lruk: same-cycle check failed");
`define LRUK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lruk: next-cycle check failed");
`else
`define LRUK_ASSERT_IMPL(label, ante, cons)
`define LRUK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/lruk_pkg.sv =====
package lruk_pkg;

    localparam int WAYS     = 16;
    localparam int SETS     = 64;
    localparam int WAY_W    = $clog2(WAYS);
    localparam int SET_W    = $clog2(SETS);
    localparam int ADDR_W   = SET_W + WAY_W;
    localparam int DEPTH    = SETS * WAYS;
    localparam int STAMP_W  = 64;
    localparam int ACTION_W = 2;
    localparam int RANK_W   = 7;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int ISSUE_W  = $clog2(WAYS + 2);

    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(10);

    localparam logic [ACTION_W-1:0] ACT_TOUCH      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INVALIDATE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_VICTIM     = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SET_W-1:0]    set_index;
        logic [WAY_W-1:0]    way_index;
        logic [STAMP_W-1:0]  now_tick;
    } t_cmd;

    typedef struct packed {
        logic [WAY_W-1:0]   victim_way;
        logic [STAMP_W-1:0] victim_stamp;
    } t_result;

endpackage

// ===== rtl/lruk_ram.sv =====
module lruk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lru_insert_at_kth_oldest_policy_unit.sv =====
// Replacement policy unit keeping one 64-bit last-use stamp per way of every set in a
// stamp RAM with one write and one read port. After reset the unit clears the RAM, one
// entry a cycle, through all 1024 entries with busy high. A touch, insert or invalidate
// is taken while idle and its (all zero) result appears on the next cycle. A victim
// search tries candidate ways in turn, 1 to 16 of them, until the rank search finds
// the insertion mark: every stamp read goes through the one RAM read port, 16 reads for
// the minimum and 17 reads per candidate for its rank count. Each result is shown for
// exactly one cycle with o_done high and cannot be held off; a new item may be started
// in that same cycle.
`include "lru_insert_at_kth_oldest_policy_unit_macros.svh"

module lru_insert_at_kth_oldest_policy_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  lruk_pkg::t_cmd                i_cmd,
    output logic                          busy,
    output logic                          o_done,
    output lruk_pkg::t_result             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lruk_pkg::RANK_W-1:0]   i_cfg_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MIN   = 2'd2;
    localparam logic [1:0] S_KSEL  = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [lruk_pkg::ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic [lruk_pkg::RANK_W-1:0]     r_rank, n_rank;
    logic [lruk_pkg::STAMP_W-1:0]    r_mark, n_mark;
    logic [lruk_pkg::ISSUE_W-1:0]    r_issue, n_issue;
    logic                            r_pend, n_pend;
    logic [lruk_pkg::CNT_W-1:0]      r_cnt_lt, n_cnt_lt;
    logic [lruk_pkg::CNT_W-1:0]      r_cnt_le, n_cnt_le;
    logic                            r_out_vld, n_out_vld;
    logic [lruk_pkg::SET_W-1:0]      r_set, n_set;
    logic [lruk_pkg::ISSUE_W-1:0]    r_ptag, n_ptag;
    logic [lruk_pkg::STAMP_W-1:0]    r_best_stamp, n_best_stamp;
    logic [lruk_pkg::WAY_W-1:0]      r_best_way, n_best_way;
    logic [lruk_pkg::WAY_W-1:0]      r_cand, n_cand;
    logic [lruk_pkg::STAMP_W-1:0]    r_cand_val, n_cand_val;
    lruk_pkg::t_result               r_out, n_out;

    logic                            ram_we;
    logic [lruk_pkg::ADDR_W-1:0]     ram_waddr;
    logic [lruk_pkg::STAMP_W-1:0]    ram_wdata;
    logic [lruk_pkg::ADDR_W-1:0]     ram_raddr;
    logic [lruk_pkg::STAMP_W-1:0]    ram_rdata;

    logic                            w_accept;
    logic                            w_set_ok;
    logic                            w_way_ok;
    logic [lruk_pkg::RANK_W-1:0]     w_k;
    logic [lruk_pkg::WAY_W-1:0]      w_jidx;
    logic [lruk_pkg::ISSUE_W-1:0]    w_jsub;
    logic [lruk_pkg::CNT_W-1:0]      w_lt_n;
    logic [lruk_pkg::CNT_W-1:0]      w_le_n;

    lruk_ram #(
        .WIDTH (lruk_pkg::STAMP_W),
        .DEPTH (lruk_pkg::DEPTH)
    ) u_stamps (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_out_vld;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_set_ok = ({1'b0, i_cmd.set_index} < (lruk_pkg::SET_W + 1)'(lruk_pkg::SETS));
    assign w_way_ok = ({1'b0, i_cmd.way_index} < (lruk_pkg::WAY_W + 1)'(lruk_pkg::WAYS));

    always_comb begin
        if (r_rank == '0) begin
            w_k = lruk_pkg::RANK_W'(1);
        end else if (r_rank > lruk_pkg::RANK_W'(lruk_pkg::WAYS)) begin
            w_k = lruk_pkg::RANK_W'(lruk_pkg::WAYS);
        end else begin
            w_k = r_rank;
        end
    end

    assign w_jsub = r_issue - lruk_pkg::ISSUE_W'(1);
    assign w_jidx = w_jsub[lruk_pkg::WAY_W-1:0];
    assign w_lt_n = r_cnt_lt + lruk_pkg::CNT_W'(ram_rdata < r_cand_val);
    assign w_le_n = r_cnt_le + lruk_pkg::CNT_W'(ram_rdata <= r_cand_val);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_rank       = r_rank;
        n_mark       = r_mark;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_cnt_lt     = r_cnt_lt;
        n_cnt_le     = r_cnt_le;
        n_out_vld    = 1'b0;
        n_set        = r_set;
        n_ptag       = r_ptag;
        n_best_stamp = r_best_stamp;
        n_best_way   = r_best_way;
        n_cand       = r_cand;
        n_cand_val   = r_cand_val;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = {i_cmd.set_index, i_cmd.way_index};
        ram_wdata    = '0;
        ram_raddr    = {r_set, r_issue[lruk_pkg::WAY_W-1:0]};

        if (i_cfg_valid) begin
            n_rank = i_cfg_data;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + lruk_pkg::ADDR_W'(1);
                if (r_clr_addr == lruk_pkg::ADDR_W'(lruk_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_out = '0;
                    if (w_set_ok && (i_cmd.action == lruk_pkg::ACT_VICTIM)) begin
                        n_state = S_MIN;
                        n_set   = i_cmd.set_index;
                        n_issue = '0;
                        n_pend  = 1'b0;
                    end else begin
                        n_out_vld = 1'b1;
                        if (w_set_ok && w_way_ok) begin
                            ram_we = 1'b1;
                            case (i_cmd.action)
                                lruk_pkg::ACT_TOUCH:  ram_wdata = i_cmd.now_tick;
                                lruk_pkg::ACT_INSERT: ram_wdata = r_mark + 64'd1;
                                default:              ram_wdata = '0;
                            endcase
                        end
                    end
                end
            end
            S_MIN: begin
                if (r_issue < lruk_pkg::ISSUE_W'(lruk_pkg::WAYS)) begin
                    n_issue = r_issue + lruk_pkg::ISSUE_W'(1);
                    n_pend  = 1'b1;
                    n_ptag  = r_issue;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if ((r_ptag == '0) || (ram_rdata < r_best_stamp)) begin
                        n_best_stamp = ram_rdata;
                        n_best_way   = r_ptag[lruk_pkg::WAY_W-1:0];
                    end
                    if (r_ptag == lruk_pkg::ISSUE_W'(lruk_pkg::WAYS - 1)) begin
                        n_state = S_KSEL;
                        n_issue = '0;
                        n_pend  = 1'b0;
                        n_cand  = '0;
                    end
                end
            end
            S_KSEL: begin
                if (r_issue == '0) begin
                    ram_raddr = {r_set, r_cand};
                end else begin
                    ram_raddr = {r_set, w_jidx};
                end
                if (r_issue <= lruk_pkg::ISSUE_W'(lruk_pkg::WAYS)) begin
                    n_issue = r_issue + lruk_pkg::ISSUE_W'(1);
                    n_pend  = 1'b1;
                    n_ptag  = r_issue;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_ptag == '0) begin
                        n_cand_val = ram_rdata;
                        n_cnt_lt   = '0;
                        n_cnt_le   = '0;
                    end else begin
                        n_cnt_lt = w_lt_n;
                        n_cnt_le = w_le_n;
                        if (r_ptag == lruk_pkg::ISSUE_W'(lruk_pkg::WAYS)) begin
                            n_issue = '0;
                            n_pend  = 1'b0;
                            if ((lruk_pkg::RANK_W'(w_lt_n) < w_k)
                                && (lruk_pkg::RANK_W'(w_le_n) >= w_k)) begin
                                n_mark                 = r_cand_val;
                                n_out_vld              = 1'b1;
                                n_out.victim_way       = r_best_way;
                                n_out.victim_stamp     = r_best_stamp;
                                n_state                = S_IDLE;
                            end else begin
                                n_cand = r_cand + lruk_pkg::WAY_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rank     <= lruk_pkg::RANK_RESET;
            r_mark     <= '0;
            r_issue    <= '0;
            r_pend     <= 1'b0;
            r_cnt_lt   <= '0;
            r_cnt_le   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rank     <= n_rank;
            r_mark     <= n_mark;
            r_issue    <= n_issue;
            r_pend     <= n_pend;
            r_cnt_lt   <= n_cnt_lt;
            r_cnt_le   <= n_cnt_le;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set        <= n_set;
        r_ptag       <= n_ptag;
        r_best_stamp <= n_best_stamp;
        r_best_way   <= n_best_way;
        r_cand       <= n_cand;
        r_cand_val   <= n_cand_val;
        r_out        <= n_out;
    end

    // A busy unit never shows a result, and a stamp update answers on the next cycle.
    `LRUK_ASSERT_IMPL(a_busy_no_done, busy, !o_done)
    `LRUK_ASSERT_NEXT(a_update_done, w_accept && (i_cmd.action != lruk_pkg::ACT_VICTIM), o_done)
    `LRUK_ASSERT_IMPL(a_rank_counts, r_state == S_KSEL, r_cnt_le >= r_cnt_lt)
    `LRUK_ASSERT_NEXT(a_search_busy, w_accept && w_set_ok && (i_cmd.action == lruk_pkg::ACT_VICTIM), busy && !o_done)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import lruk_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int TAIL_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1000;

    typedef enum logic [1:0] {
        ENTRY_CMD,
        ENTRY_RANK,
        ENTRY_SETTLE
    } entry_kind_e;

    typedef struct {
        entry_kind_e       kind;
        t_cmd              cmd;
        logic [RANK_W-1:0] rank;
        bit                may_idle;
    } backlog_entry_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    t_cmd              i_cmd = '0;
    logic              busy;
    logic              o_done;
    t_result           o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [RANK_W-1:0] i_cfg_data = '0;

    backlog_entry_t    cmd_backlog[$];
    t_result           predicted_victims[$];

    logic [STAMP_W-1:0] stamp_mem [SETS][WAYS];
    logic [STAMP_W-1:0] ins_mark = '0;
    logic [RANK_W-1:0]  rank_reg = RANK_RESET;

    int issued_cnt  = 0;
    int result_cnt  = 0;
    int error_cnt   = 0;
    int cycle_cnt   = 0;

    lru_insert_at_kth_oldest_policy_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [STAMP_W-1:0] want,
                                   logic [STAMP_W-1:0] got);
        $display("MISMATCH at cycle %0d: %s expected %h got %h", cycle_cnt, what, want, got);
        error_cnt++;
    endtask

    // Applies one accepted item to the policy state and returns its result.
    function automatic t_result predict_policy(t_cmd c);
        t_result            res;
        int                 k;
        int                 best;
        int                 n_less;
        int                 n_leq;
        bit                 found;
        logic [STAMP_W-1:0] s;
        res = '0;
        if (c.action == ACT_VICTIM) begin
            k = int'(rank_reg);
            if (k < 1) k = 1;
            if (k > WAYS) k = WAYS;
            best = 0;
            for (int w = 1; w < WAYS; w++) begin
                if (stamp_mem[c.set_index][w] < stamp_mem[c.set_index][best]) best = w;
            end
            found = 0;
            for (int w = 0; w < WAYS && !found; w++) begin
                s = stamp_mem[c.set_index][w];
                n_less = 0;
                n_leq = 0;
                for (int v = 0; v < WAYS; v++) begin
                    if (stamp_mem[c.set_index][v] < s) n_less++;
                    if (stamp_mem[c.set_index][v] <= s) n_leq++;
                end
                if (n_less < k && k <= n_leq) begin
                    ins_mark = s;
                    found = 1;
                end
            end
            res.victim_way = WAY_W'(best);
            res.victim_stamp = stamp_mem[c.set_index][best];
        end else if (c.action == ACT_TOUCH) begin
            stamp_mem[c.set_index][c.way_index] = c.now_tick;
        end else if (c.action == ACT_INSERT) begin
            stamp_mem[c.set_index][c.way_index] = ins_mark + 64'd1;
        end else begin
            stamp_mem[c.set_index][c.way_index] = '0;
        end
        return res;
    endfunction

    function automatic void push_cmd(logic [ACTION_W-1:0] action, int set_idx, int way_idx,
                                     logic [STAMP_W-1:0] tick, bit may_idle);
        backlog_entry_t e;
        e.kind = ENTRY_CMD;
        e.cmd.action = action;
        e.cmd.set_index = SET_W'(set_idx);
        e.cmd.way_index = WAY_W'(way_idx);
        e.cmd.now_tick = tick;
        e.rank = '0;
        e.may_idle = may_idle;
        cmd_backlog.push_back(e);
    endfunction

    function automatic void push_marker(entry_kind_e kind, logic [RANK_W-1:0] rank);
        backlog_entry_t e;
        e.kind = kind;
        e.cmd = '0;
        e.rank = rank;
        e.may_idle = 1'b0;
        cmd_backlog.push_back(e);
    endfunction

    // Most requests go to a few sets so that searches see well-filled sets with
    // repeated stamps; the rest spread over all sets and the full tick range.
    function automatic void push_random_cmd(bit may_idle);
        logic [ACTION_W-1:0] action;
        logic [STAMP_W-1:0]  tick;
        int                  pick;
        int                  set_idx;
        pick = $urandom_range(99);
        if (pick < 35) action = ACT_TOUCH;
        else if (pick < 55) action = ACT_INSERT;
        else if (pick < 70) action = ACT_INVALIDATE;
        else action = ACT_VICTIM;
        case ($urandom_range(9))
            0, 1, 2, 3: tick = 64'($urandom_range(24));
            8:          tick = ~64'($urandom_range(3));
            9:          tick = '0;
            default:    tick = {$urandom, $urandom};
        endcase
        set_idx = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(SETS - 1);
        push_cmd(action, set_idx, $urandom_range(WAYS - 1), tick, may_idle);
    endfunction

    always @(posedge i_clk) begin : driver
        logic              nxt_start;
        logic              nxt_cfg_valid;
        t_cmd              nxt_cmd;
        logic [RANK_W-1:0] nxt_cfg_data;
        backlog_entry_t    head;
        nxt_start = start;
        nxt_cfg_valid = i_cfg_valid;
        nxt_cmd = i_cmd;
        nxt_cfg_data = i_cfg_data;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            nxt_cfg_valid = 1'b0;
        end else begin
            if (start && !busy) begin
                predicted_victims.push_back(predict_policy(i_cmd));
                issued_cnt++;
                void'(cmd_backlog.pop_front());
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                rank_reg = i_cfg_data;
                void'(cmd_backlog.pop_front());
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_start && !nxt_cfg_valid && cmd_backlog.size() != 0) begin
                head = cmd_backlog[0];
                case (head.kind)
                    ENTRY_CMD: begin
                        if (!head.may_idle || $urandom_range(99) >= 21) begin
                            nxt_start = 1'b1;
                            nxt_cmd = head.cmd;
                        end
                    end
                    ENTRY_RANK: begin
                        if (issued_cnt == result_cnt && !busy) begin
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_data = head.rank;
                        end
                    end
                    default: begin
                        if (issued_cnt == result_cnt) void'(cmd_backlog.pop_front());
                    end
                endcase
            end
        end
        start <= nxt_start;
        i_cmd <= nxt_cmd;
        i_cfg_valid <= nxt_cfg_valid;
        i_cfg_data <= nxt_cfg_data;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_done) begin
            result_cnt <= result_cnt + 1;
            if (predicted_victims.size() == 0) begin
                report_mismatch("unexpected result, way/stamp", '0, o_result.victim_stamp);
            end else begin
                want = predicted_victims.pop_front();
                if (o_result.victim_way !== want.victim_way)
                    report_mismatch("victim_way", 64'(want.victim_way), 64'(o_result.victim_way));
                if (o_result.victim_stamp !== want.victim_stamp)
                    report_mismatch("victim_stamp", want.victim_stamp, o_result.victim_stamp);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("lru_insert_at_kth_oldest_policy_unit test failed");
            $finish;
        end
    end

    initial begin : run
        logic [RANK_W-1:0] phase_ranks [10];
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) stamp_mem[s][w] = '0;
        end

        // An insert before any search takes the reset mark, then ties go to way 0.
        push_cmd(ACT_INSERT, 0, 3, 64'd77, 1'b1);
        push_cmd(ACT_VICTIM, 0, 9, '1, 1'b1);
        push_cmd(ACT_TOUCH, 63, 15, '1, 1'b1);
        push_cmd(ACT_TOUCH, 63, 0, 64'h8000_0000_0000_0000, 1'b1);
        push_cmd(ACT_INVALIDATE, 63, 0, '0, 1'b1);
        push_cmd(ACT_VICTIM, 63, 0, '0, 1'b1);
        push_cmd(ACT_TOUCH, 1, 5, 64'd3, 1'b1);
        push_cmd(ACT_TOUCH, 1, 0, 64'd3, 1'b1);
        push_cmd(ACT_VICTIM, 1, 2, 64'd0, 1'b1);

        // A rank above the way count takes the largest stamp, so the insert wraps.
        push_marker(ENTRY_RANK, 7'd127);
        push_cmd(ACT_TOUCH, 2, 7, '1, 1'b1);
        push_cmd(ACT_VICTIM, 2, 0, '0, 1'b1);
        push_cmd(ACT_INSERT, 2, 1, '0, 1'b1);
        push_cmd(ACT_VICTIM, 2, 0, '0, 1'b1);

        // A rank of zero acts as one.
        push_marker(ENTRY_RANK, 7'd0);
        for (int w = 0; w < WAYS; w++) push_cmd(ACT_TOUCH, 3, w, 64'(w + 5), 1'b0);
        push_cmd(ACT_VICTIM, 3, 0, '0, 1'b1);
        push_cmd(ACT_INSERT, 3, 4, '0, 1'b1);
        push_cmd(ACT_VICTIM, 3, 0, '0, 1'b1);

        phase_ranks = '{7'd1, 7'd16, 7'd17, 7'd64, 7'd2, 7'd127, 7'd0, 7'd8,
                        7'($urandom_range(127)), 7'd10};
        for (int p = 0; p < 10; p++) begin
            push_marker(ENTRY_RANK, phase_ranks[p]);
            for (int i = 0; i < RANDOM_ITEMS / 10; i++) begin
                push_random_cmd(p != 4);
                if (i == 50 && (p % 3) == 0) push_marker(ENTRY_SETTLE, '0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_backlog.size() != 0 || issued_cnt != result_cnt) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predicted_victims.size() != 0)
            report_mismatch("results still expected", 64'(predicted_victims.size()), '0);
        if (error_cnt == 0) begin
            $display("lru_insert_at_kth_oldest_policy_unit test passed");
        end else begin
            $display("lru_insert_at_kth_oldest_policy_unit test failed");
        end
        $finish;
    end
endmodule
